// ----- sv/mtf_pkg.sv -----
package mtf_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = SLOT_W + 1;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int ID_W          = 32;
  localparam int IP_W          = 32;
  localparam int DEST_SLOT_W   = 6;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 40;
  localparam int OUT_PAD_W     = OUT_DATA_W - IP_W - DEST_SLOT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_FANOUT = 4'b1000
  } state_t;

  typedef struct packed {
    logic              en;
    logic              claim;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [IP_W-1:0]   ip;
  } tbl_wr_t;

endpackage

// ----- sv/member_table_fanout_unit.sv -----
// Flow: an accepted word is searched over one scan of the table, registered in the
// update state, then fanned out over a second scan of the table plus output stalls.
// Throughput: a new word is accepted only in idle, after the fan-out of the last one ends,
// so each word takes two scans of the table memory.
// Reset: rst_n synchronous active low; clears all used bits, no clearing pass needed.
module member_table_fanout_unit import mtf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] src_id, [63:32] source_ip
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] dest_ip, [37:32] dest_slot, [39:38] zero
  output logic                  out_tlast   // last_dest
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         addr_r, addr_nxt;
  logic                     chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0]        chk_slot_r, chk_slot_nxt;
  logic                     match_v_r, match_v_nxt;
  logic [SLOT_W-1:0]        match_slot_r, match_slot_nxt;
  logic                     free_v_r, free_v_nxt;
  logic [SLOT_W-1:0]        free_slot_r, free_slot_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [IP_W-1:0]          pend_ip_r, pend_ip_nxt;
  logic [SLOT_W-1:0]        pend_slot_r, pend_slot_nxt;
  logic [RES_CNT_W-1:0]     qual_cnt_r, qual_cnt_nxt;
  logic                     out_v_r, out_v_nxt;
  logic [IP_W-1:0]          out_ip_r, out_ip_nxt;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [ID_W-1:0]          id_r;
  logic [IP_W-1:0]          src_r;

  logic                     rd_en;
  logic [ID_W-1:0]          rd_id;
  logic [IP_W-1:0]          rd_ip;
  logic [TABLE_ENTRIES-1:0] used;
  tbl_wr_t                  wr;
  logic                     in_acc;
  logic                     issuing;
  logic                     out_free;
  logic                     chk_used;
  logic                     qual;
  logic                     stall;

  mtf_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (addr_r[SLOT_W-1:0]),
    .rd_id   (rd_id),
    .rd_ip   (rd_ip),
    .wr      (wr),
    .used    (used)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign issuing   = (addr_r < CNT_W'(TABLE_ENTRIES));
  assign out_free  = !out_v_r || out_tready;
  assign chk_used  = used[chk_slot_r];
  assign qual      = (state_r == ST_FANOUT) && chk_v_r && chk_used && (rd_ip != src_r) &&
                     (qual_cnt_r < RES_CNT_W'(MAX_RESULTS));
  assign stall     = qual && pend_v_r && !out_free;
  assign rd_en     = ((state_r == ST_SEARCH) || ((state_r == ST_FANOUT) && !stall)) && issuing;

  always_comb begin
    wr          = '0;
    wr.slot     = match_v_r ? match_slot_r : free_slot_r;
    wr.id       = id_r;
    wr.ip       = src_r;
    if (state_r == ST_UPDATE) begin
      wr.en    = match_v_r || free_v_r;
      wr.claim = !match_v_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    chk_v_nxt      = chk_v_r;
    chk_slot_nxt   = chk_slot_r;
    match_v_nxt    = match_v_r;
    match_slot_nxt = match_slot_r;
    free_v_nxt     = free_v_r;
    free_slot_nxt  = free_slot_r;
    pend_v_nxt     = pend_v_r;
    pend_ip_nxt    = pend_ip_r;
    pend_slot_nxt  = pend_slot_r;
    qual_cnt_nxt   = qual_cnt_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_ip_nxt     = out_ip_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt   = ST_SEARCH;
          addr_nxt    = '0;
          chk_v_nxt   = 1'b0;
          match_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
        end
      end
      ST_SEARCH: begin
        chk_v_nxt    = issuing;
        chk_slot_nxt = addr_r[SLOT_W-1:0];
        if (issuing) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (chk_v_r) begin
          if (chk_used && (rd_id == id_r) && !match_v_r) begin
            match_v_nxt    = 1'b1;
            match_slot_nxt = chk_slot_r;
          end
          if (!chk_used && !free_v_r) begin
            free_v_nxt    = 1'b1;
            free_slot_nxt = chk_slot_r;
          end
        end
        if (!issuing && !chk_v_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt    = ST_FANOUT;
        addr_nxt     = '0;
        chk_v_nxt    = 1'b0;
        pend_v_nxt   = 1'b0;
        qual_cnt_nxt = '0;
      end
      ST_FANOUT: begin
        if (!stall) begin
          chk_v_nxt    = issuing;
          chk_slot_nxt = addr_r[SLOT_W-1:0];
          if (issuing) begin
            addr_nxt = addr_r + 1'b1;
          end
          if (qual) begin
            qual_cnt_nxt  = qual_cnt_r + 1'b1;
            pend_v_nxt    = 1'b1;
            pend_ip_nxt   = rd_ip;
            pend_slot_nxt = chk_slot_r;
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_ip_nxt   = pend_ip_r;
              out_slot_nxt = pend_slot_r;
              out_last_nxt = 1'b0;
            end
          end
        end
        if (!issuing && !chk_v_r) begin
          if (!pend_v_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_v_nxt    = 1'b1;
            out_ip_nxt   = pend_ip_r;
            out_slot_nxt = pend_slot_r;
            out_last_nxt = 1'b1;
            pend_v_nxt   = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      addr_r   <= '0;
      chk_v_r  <= 1'b0;
      match_v_r <= 1'b0;
      free_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      qual_cnt_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      chk_v_r  <= chk_v_nxt;
      match_v_r <= match_v_nxt;
      free_v_r <= free_v_nxt;
      pend_v_r <= pend_v_nxt;
      qual_cnt_r <= qual_cnt_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_slot_r   <= chk_slot_nxt;
    match_slot_r <= match_slot_nxt;
    free_slot_r  <= free_slot_nxt;
    pend_ip_r    <= pend_ip_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_ip_r     <= out_ip_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
    if (in_acc) begin
      id_r  <= in_tdata[ID_W-1:0];
      src_r <= in_tdata[ID_W +: IP_W];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {OUT_PAD_W'(0), DEST_SLOT_W'(out_slot_r), out_ip_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/mtf_table.sv -----
module mtf_table import mtf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [SLOT_W-1:0]        rd_addr,
  output logic [ID_W-1:0]          rd_id,
  output logic [IP_W-1:0]          rd_ip,
  input  tbl_wr_t                  wr,
  output logic [TABLE_ENTRIES-1:0] used
);

  logic [ID_W-1:0]          id_mem [TABLE_ENTRIES];
  logic [IP_W-1:0]          ip_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_r;
  logic [ID_W-1:0]          rd_id_r;
  logic [IP_W-1:0]          rd_ip_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ip_mem[wr.slot] <= wr.ip;
      if (wr.claim) begin
        id_mem[wr.slot] <= wr.id;
      end
    end
    if (rd_en) begin
      rd_id_r <= id_mem[rd_addr];
      rd_ip_r <= ip_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.en && wr.claim) begin
      used_r[wr.slot] <= 1'b1;
    end
  end

  assign rd_id = rd_id_r;
  assign rd_ip = rd_ip_r;
  assign used  = used_r;

endmodule

// ----- sv/mtf_checker.sv -----
module mtf_checker import mtf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after accept");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] == '0)
    else $error("padding bits not zero");

endmodule

bind member_table_fanout_unit mtf_checker u_mtf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
